>>> hdl/multivariate_polynomial_eval_assert.svh
// Assertion macros shared by the polynomial evaluator modules.
// Expects clk and rst_n in the scope of each use.
`ifndef MULTIVARIATE_POLYNOMIAL_EVAL_ASSERT_SVH
`define MULTIVARIATE_POLYNOMIAL_EVAL_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define MPE_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define MPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/mpe_pkg.sv
// Types and constants for the multivariate polynomial evaluator.
// No dependencies; used by multivariate_polynomial_eval and mpe_mul.
package mpe_pkg;

    localparam int VAR_W     = 32;
    localparam int COEF_W    = 48;
    localparam int MAX_ORDER = 6;
    localparam int FRAC      = 28;
    localparam int MONO_W    = 47;
    localparam int OP_W      = 48;
    localparam int PROD_W    = 2 * OP_W;
    localparam int RES_W     = PROD_W - FRAC;
    localparam int ACC_W     = 80;
    localparam int TERM_W    = 8;
    localparam int ORD_W     = 3;
    localparam int CFG_AW    = 3;

    localparam logic [MONO_W-1:0] ONE = MONO_W'(1) << FRAC;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic [0:0] REG_VAR_COUNT  = 1'b0;
    localparam logic [0:0] REG_POLY_ORDER = 1'b1;

    typedef struct packed {
        logic                     opcode;
        logic [7:0]               coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [VAR_W-1:0]  var_a;
        logic signed [VAR_W-1:0]  var_b;
        logic signed [VAR_W-1:0]  var_c;
        logic signed [VAR_W-1:0]  var_d;
    } req_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] poly_value;
        logic                     saturated;
    } res_t;

    typedef struct packed {
        logic            start;
        logic [OP_W-1:0] a;
        logic [OP_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] value;
    } mul_rsp_t;

endpackage

>>> hdl/multivariate_polynomial_eval.sv
// Top level of the multivariate polynomial evaluator: sequencer, power and
// accumulator registers, APB registers. Depends on mpe_pkg, mpe_mul, mpe_ram.
//
// Request channel (req_valid/req_stall/req_data): opcode 0 stores one
// coefficient, opcode 1 evaluates the polynomial at var_a..var_d.
// Result channel (res_valid/res_stall/res_data): one result per evaluation,
// none per write. A write is taken while idle and does not raise req_stall.
// Each product goes through one shared multiplier built from four 24x24
// partial steps and a rounding step. An evaluation first forms the variable
// powers, then per term builds the monomial, multiplying in the power for
// each nonzero exponent of var_b, var_c or var_d, and scales it by the
// coefficient into the sum, then clips the sum.
// req_stall is high for the whole evaluation.
// A finished result waits in the output register; a stalled receiver holds
// it there and the next evaluation waits at its end for the slot to free.
// Reset clears the registers to var_count 4 and poly_order 6 and empties the
// output; the coefficient store is undefined until written.
`include "multivariate_polynomial_eval_assert.svh"
module multivariate_polynomial_eval #(
    parameter int MAX_TERMS = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  mpe_pkg::req_t               req_data,
    output logic                        res_valid,
    input  logic                        res_stall,
    output mpe_pkg::res_t               res_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mpe_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int AW = $clog2(MAX_TERMS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_POW_ISSUE,
        S_POW_WAIT,
        S_MONO_INIT,
        S_MONO_STEP,
        S_MONO_WAIT,
        S_TERM_ISSUE,
        S_TERM_WAIT,
        S_SAT
    } state_t;

    localparam logic signed [mpe_pkg::ACC_W-1:0] POS_LIM =
        {{(mpe_pkg::ACC_W - mpe_pkg::COEF_W + 1){1'b0}}, {(mpe_pkg::COEF_W - 1){1'b1}}};
    localparam logic signed [mpe_pkg::ACC_W-1:0] NEG_LIM =
        {{(mpe_pkg::ACC_W - mpe_pkg::COEF_W + 1){1'b1}}, {(mpe_pkg::COEF_W - 1){1'b0}}};

    state_t                             state_reg, state_next;
    logic [2:0]                         var_count_reg, var_count_next;
    logic [2:0]                         poly_order_reg, poly_order_next;
    logic                               res_valid_reg, res_valid_next;
    mpe_pkg::res_t                      res_reg, res_next;
    logic [2:0]                         nv_reg, nv_next;
    logic [mpe_pkg::ORD_W-1:0]          ord_reg, ord_next;
    logic [mpe_pkg::VAR_W-1:0]          mag_reg [4];
    logic [mpe_pkg::VAR_W-1:0]          mag_next [4];
    logic [3:0]                         neg_reg, neg_next;
    logic [mpe_pkg::MONO_W-1:0]         pw_reg [4][mpe_pkg::MAX_ORDER];
    logic [mpe_pkg::MONO_W-1:0]         pw_next [4][mpe_pkg::MAX_ORDER];
    logic [1:0]                         pv_reg, pv_next;
    logic [2:0]                         pe_reg, pe_next;
    logic [2:0]                         n_reg, n_next;
    logic [2:0]                         b_reg, b_next;
    logic [2:0]                         c_reg, c_next;
    logic [2:0]                         d_reg, d_next;
    logic [mpe_pkg::TERM_W-1:0]         idx_reg, idx_next;
    logic [1:0]                         ms_reg, ms_next;
    logic [mpe_pkg::MONO_W-1:0]         mono_reg, mono_next;
    logic                               mono_neg_reg, mono_neg_next;
    logic                               tneg_reg, tneg_next;
    logic signed [mpe_pkg::ACC_W-1:0]   acc_reg, acc_next;

    mpe_pkg::mul_req_t                  mul_req;
    mpe_pkg::mul_rsp_t                  mul_rsp;
    logic                               ram_we;
    logic [AW-1:0]                      ram_waddr;
    logic [mpe_pkg::COEF_W-1:0]         coef_q;
    logic [mpe_pkg::COEF_W-1:0]         coef_mag;
    logic                               req_fire;
    logic                               cfg_wr;
    logic [2:0]                         a_exp;
    logic [2:0]                         x_exp;
    logic [1:0]                         pow_v;
    logic [2:0]                         pow_e;
    logic [mpe_pkg::MONO_W-1:0]         pow_val;
    logic [3:0]                         s_b1, s_c1, s_d1;
    logic                               term_last;
    logic [mpe_pkg::ACC_W-1:0]          term_ext;
    logic signed [mpe_pkg::ACC_W-1:0]   acc_sum;
    logic [mpe_pkg::VAR_W-1:0]          vin [4];

    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;

    assign ram_we    = req_fire && (req_data.opcode == mpe_pkg::OP_WRITE)
                       && (32'(req_data.coef_index) < MAX_TERMS);
    assign ram_waddr = AW'(req_data.coef_index);

    mpe_ram #(
        .WIDTH (mpe_pkg::COEF_W),
        .DEPTH (MAX_TERMS)
    ) u_coef (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req_data.coef_value),
        .raddr (AW'(idx_reg)),
        .rdata (coef_q)
    );

    mpe_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    always_comb
    begin
        unique case (paddr[2])
            mpe_pkg::REG_VAR_COUNT:  prdata = 32'(var_count_reg);
            mpe_pkg::REG_POLY_ORDER: prdata = 32'(poly_order_reg);
            default:                 prdata = '0;
        endcase
    end

    always_comb
    begin
        vin[0] = req_data.var_a;
        vin[1] = req_data.var_b;
        vin[2] = req_data.var_c;
        vin[3] = req_data.var_d;
        coef_mag = coef_q[mpe_pkg::COEF_W-1] ? (~coef_q + 1'b1) : coef_q;
        a_exp = n_reg - b_reg - c_reg - d_reg;
        case (ms_reg)
            2'd0:    x_exp = a_exp;
            2'd1:    x_exp = b_reg;
            2'd2:    x_exp = c_reg;
            default: x_exp = d_reg;
        endcase
        if (state_reg == S_POW_ISSUE)
        begin
            pow_v = pv_reg;
            pow_e = pe_reg - 3'd1;
        end
        else
        begin
            pow_v = ms_reg;
            pow_e = x_exp;
        end
        pow_val = (pow_e == 3'd0) ? mpe_pkg::ONE : pw_reg[pow_v][pow_e - 3'd1];
        s_b1 = 4'(b_reg) + 4'(c_reg) + 4'(d_reg) + 4'd1;
        s_c1 = 4'(c_reg) + 4'(d_reg) + 4'd1;
        s_d1 = 4'(d_reg) + 4'd1;
        term_ext = mpe_pkg::ACC_W'(mul_rsp.value);
        acc_sum  = tneg_reg ? (acc_reg - $signed(term_ext)) : (acc_reg + $signed(term_ext));
    end

    always_comb
    begin
        state_next      = state_reg;
        var_count_next  = var_count_reg;
        poly_order_next = poly_order_reg;
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;
        nv_next         = nv_reg;
        ord_next        = ord_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        pw_next         = pw_reg;
        pv_next         = pv_reg;
        pe_next         = pe_reg;
        n_next          = n_reg;
        b_next          = b_reg;
        c_next          = c_reg;
        d_next          = d_reg;
        idx_next        = idx_reg;
        ms_next         = ms_reg;
        mono_next       = mono_reg;
        mono_neg_next   = mono_neg_reg;
        tneg_next       = tneg_reg;
        acc_next        = acc_reg;
        term_last       = 1'b0;
        mul_req.start   = 1'b0;
        mul_req.a       = mpe_pkg::OP_W'(mono_reg);
        mul_req.b       = mpe_pkg::OP_W'(pow_val);

        if (cfg_wr)
        begin
            unique case (paddr[2])
                mpe_pkg::REG_VAR_COUNT:  var_count_next  = pwdata[2:0];
                mpe_pkg::REG_POLY_ORDER: poly_order_next = pwdata[2:0];
                default:                 var_count_next  = var_count_reg;
            endcase
        end

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && (req_data.opcode == mpe_pkg::OP_EVAL))
                begin
                    nv_next  = (var_count_reg < 3'd2) ? 3'd2
                             : ((var_count_reg > 3'd4) ? 3'd4 : var_count_reg);
                    ord_next = (poly_order_reg > 3'(mpe_pkg::MAX_ORDER))
                             ? 3'(mpe_pkg::MAX_ORDER) : poly_order_reg;
                    for (int v = 0; v < 4; v++)
                    begin
                        neg_next[v] = vin[v][mpe_pkg::VAR_W-1];
                        mag_next[v] = vin[v][mpe_pkg::VAR_W-1] ? (~vin[v] + 1'b1) : vin[v];
                    end
                    acc_next = '0;
                    n_next   = '0;
                    b_next   = '0;
                    c_next   = '0;
                    d_next   = '0;
                    idx_next = '0;
                    pv_next  = '0;
                    pe_next  = 3'd1;
                    state_next = (ord_next == '0) ? S_MONO_INIT : S_POW_ISSUE;
                end
            end
            S_POW_ISSUE:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = mpe_pkg::OP_W'(pow_val);
                mul_req.b     = mpe_pkg::OP_W'(mag_reg[pv_reg]);
                state_next    = S_POW_WAIT;
            end
            S_POW_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    pw_next[pv_reg][pe_reg - 3'd1] = mul_rsp.value[mpe_pkg::MONO_W-1:0];
                    if (pe_reg == ord_reg)
                    begin
                        pe_next = 3'd1;
                        if (3'(pv_reg) + 3'd1 == nv_reg)
                        begin
                            state_next = S_MONO_INIT;
                        end
                        else
                        begin
                            pv_next    = pv_reg + 2'd1;
                            state_next = S_POW_ISSUE;
                        end
                    end
                    else
                    begin
                        pe_next    = pe_reg + 3'd1;
                        state_next = S_POW_ISSUE;
                    end
                end
            end
            S_MONO_INIT:
            begin
                mono_next     = mpe_pkg::ONE;
                mono_neg_next = 1'b0;
                ms_next       = '0;
                state_next    = S_MONO_STEP;
            end
            S_MONO_STEP:
            begin
                if (x_exp == 3'd0)
                begin
                    if (ms_reg == 2'd3)
                    begin
                        state_next = S_TERM_ISSUE;
                    end
                    else
                    begin
                        ms_next = ms_reg + 2'd1;
                    end
                end
                else if (ms_reg == 2'd0)
                begin
                    mono_next     = pow_val;
                    mono_neg_next = neg_reg[0] & x_exp[0];
                    ms_next       = 2'd1;
                end
                else
                begin
                    mul_req.start = 1'b1;
                    mono_neg_next = mono_neg_reg ^ (neg_reg[ms_reg] & x_exp[0]);
                    state_next    = S_MONO_WAIT;
                end
            end
            S_MONO_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    mono_next = mul_rsp.value[mpe_pkg::MONO_W-1:0];
                    if (ms_reg == 2'd3)
                    begin
                        state_next = S_TERM_ISSUE;
                    end
                    else
                    begin
                        ms_next    = ms_reg + 2'd1;
                        state_next = S_MONO_STEP;
                    end
                end
            end
            S_TERM_ISSUE:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = coef_mag;
                mul_req.b     = mpe_pkg::OP_W'(mono_reg);
                tneg_next     = mono_neg_reg ^ coef_q[mpe_pkg::COEF_W-1];
                state_next    = S_TERM_WAIT;
            end
            S_TERM_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    acc_next = acc_sum;
                    if (s_b1 <= 4'(n_reg))
                    begin
                        b_next = b_reg + 3'd1;
                    end
                    else if ((nv_reg > 3'd2) && (s_c1 <= 4'(n_reg)))
                    begin
                        b_next = '0;
                        c_next = c_reg + 3'd1;
                    end
                    else if ((nv_reg > 3'd3) && (s_d1 <= 4'(n_reg)))
                    begin
                        b_next = '0;
                        c_next = '0;
                        d_next = d_reg + 3'd1;
                    end
                    else
                    begin
                        b_next    = '0;
                        c_next    = '0;
                        d_next    = '0;
                        n_next    = n_reg + 3'd1;
                        term_last = (n_reg == ord_reg);
                    end
                    idx_next = idx_reg + 1'b1;
                    if (term_last || (32'(idx_reg) + 32'd1 >= MAX_TERMS))
                    begin
                        state_next = S_SAT;
                    end
                    else
                    begin
                        state_next = S_MONO_INIT;
                    end
                end
            end
            S_SAT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    if (acc_reg > POS_LIM)
                    begin
                        res_next.poly_value = POS_LIM[mpe_pkg::COEF_W-1:0];
                        res_next.saturated  = 1'b1;
                    end
                    else if (acc_reg < NEG_LIM)
                    begin
                        res_next.poly_value = NEG_LIM[mpe_pkg::COEF_W-1:0];
                        res_next.saturated  = 1'b1;
                    end
                    else
                    begin
                        res_next.poly_value = acc_reg[mpe_pkg::COEF_W-1:0];
                        res_next.saturated  = 1'b0;
                    end
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            var_count_reg  <= 3'd4;
            poly_order_reg <= 3'd6;
            res_valid_reg  <= 1'b0;
            res_reg        <= '0;
            nv_reg         <= 3'd4;
            ord_reg        <= '0;
            mag_reg        <= '{default: '0};
            neg_reg        <= '0;
            pw_reg         <= '{default: '{default: '0}};
            pv_reg         <= '0;
            pe_reg         <= 3'd1;
            n_reg          <= '0;
            b_reg          <= '0;
            c_reg          <= '0;
            d_reg          <= '0;
            idx_reg        <= '0;
            ms_reg         <= '0;
            mono_reg       <= '0;
            mono_neg_reg   <= 1'b0;
            tneg_reg       <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            var_count_reg  <= var_count_next;
            poly_order_reg <= poly_order_next;
            res_valid_reg  <= res_valid_next;
            res_reg        <= res_next;
            nv_reg         <= nv_next;
            ord_reg        <= ord_next;
            mag_reg        <= mag_next;
            neg_reg        <= neg_next;
            pw_reg         <= pw_next;
            pv_reg         <= pv_next;
            pe_reg         <= pe_next;
            n_reg          <= n_next;
            b_reg          <= b_next;
            c_reg          <= c_next;
            d_reg          <= d_next;
            idx_reg        <= idx_next;
            ms_reg         <= ms_next;
            mono_reg       <= mono_next;
            mono_neg_reg   <= mono_neg_next;
            tneg_reg       <= tneg_next;
            acc_reg        <= acc_next;
        end
    end

    `MPE_ASSERT_IMPLY(a_idx_range, state_reg == S_TERM_ISSUE,
        32'(idx_reg) < MAX_TERMS, "term index beyond store")
    `MPE_ASSERT_IMPLY(a_mono_range,
        state_reg == S_TERM_ISSUE && mono_reg[mpe_pkg::MONO_W-1],
        mono_reg[mpe_pkg::MONO_W-2:0] == '0, "monomial out of range")
    `MPE_ASSERT_IMPLY(a_res_src, $rose(res_valid_reg),
        $past(state_reg == S_SAT), "result without evaluation")
    `MPE_ASSERT_IMPLY(a_mul_owner, mul_rsp.done,
        state_reg == S_POW_WAIT || state_reg == S_MONO_WAIT || state_reg == S_TERM_WAIT,
        "product with nobody waiting")

endmodule

>>> hdl/mpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpe_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/mpe_mul.sv
// Shared multiplier: unsigned OP_W x OP_W in four half-width partial steps,
// then rounding by FRAC bits half up. Depends on mpe_pkg.
`include "multivariate_polynomial_eval_assert.svh"
module mpe_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  mpe_pkg::mul_req_t req,
    output mpe_pkg::mul_rsp_t rsp
);

    localparam int HW = mpe_pkg::OP_W / 2;

    logic                       busy_reg;
    logic                       rnd_reg;
    logic                       done_reg;
    logic [1:0]                 cnt_reg;
    logic [mpe_pkg::OP_W-1:0]   a_reg;
    logic [mpe_pkg::OP_W-1:0]   b_reg;
    logic [mpe_pkg::PROD_W-1:0] prod_reg;
    logic [mpe_pkg::RES_W-1:0]  value_reg;

    logic [HW-1:0]              a_half;
    logic [HW-1:0]              b_half;
    logic [2*HW-1:0]            pp;
    logic [mpe_pkg::PROD_W-1:0] pp_sh;
    logic [mpe_pkg::PROD_W-1:0] rounded;

    always_comb
    begin
        a_half = cnt_reg[0] ? a_reg[2*HW-1:HW] : a_reg[HW-1:0];
        b_half = cnt_reg[1] ? b_reg[2*HW-1:HW] : b_reg[HW-1:0];
        pp     = a_half * b_half;
        case ({1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]})
            2'd0:    pp_sh = mpe_pkg::PROD_W'(pp);
            2'd1:    pp_sh = mpe_pkg::PROD_W'(pp) << HW;
            default: pp_sh = mpe_pkg::PROD_W'(pp) << (2 * HW);
        endcase
        rounded = prod_reg + (mpe_pkg::PROD_W'(1) << (mpe_pkg::FRAC - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            rnd_reg   <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            prod_reg  <= '0;
            value_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                a_reg    <= req.a;
                b_reg    <= req.b;
                prod_reg <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                prod_reg <= prod_reg + pp_sh;
                cnt_reg  <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    rnd_reg  <= 1'b1;
                end
            end
            else if (rnd_reg)
            begin
                value_reg <= rounded[mpe_pkg::FRAC +: mpe_pkg::RES_W];
                done_reg  <= 1'b1;
                rnd_reg   <= 1'b0;
            end
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

    `MPE_ASSERT_IMPLY(a_start_idle, req.start, !busy_reg && !rnd_reg, "start while busy")
    `MPE_ASSERT_IMPLY(a_rnd_excl, rnd_reg, !busy_reg, "round and busy overlap")
    `MPE_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg, "done longer than one cycle")

endmodule
